@@ hdl/lblc_pkg.sv @@
// shared constants, register codes and pipeline payload types for the line clipper
// no dependencies; used by liang_barsky_line_clip_core
`default_nettype none

package lblc_pkg;

    // coordinate and parameter formats
    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_W         = PARAM_FRAC_BITS + 1;

    // doubled-resolution edge values and edge distances
    localparam int EDGE_W   = COORD_BITS + 4;
    // divisor magnitude, twice a coordinate difference
    localparam int DEN_W    = COORD_BITS + 2;
    // integer quotient bit plus one extra fraction bit for rounding
    localparam int QUO_BITS = PARAM_FRAC_BITS + 2;

    // divider pipeline: quotient bits resolved per stage
    localparam int DIV_STEPS  = 6;
    localparam int DIV_STAGES = (QUO_BITS + DIV_STEPS - 1) / DIV_STEPS;

    // signed delta times zero-extended parameter
    localparam int PROD_W = COORD_BITS + PARAM_W + 2;

    localparam int CFG_IDX_W = 4;
    localparam int NUM_EDGES = 4;

    localparam logic [PARAM_W-1:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

    localparam logic signed [EDGE_W-1:0] EDGE_LO = EDGE_W'(-(64'sd1 <<< COORD_BITS));
    localparam logic signed [EDGE_W-1:0] EDGE_HI = EDGE_W'((64'sd1 <<< COORD_BITS) - 2);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = CFG_IDX_W'(0),
        REG_CENTER_Y = CFG_IDX_W'(1),
        REG_LENGTH   = CFG_IDX_W'(2),
        REG_BREADTH  = CFG_IDX_W'(3)
    } cfg_reg_t;

    // segment data carried along the pipe
    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS:0]   dx;
        logic signed [COORD_BITS:0]   dy;
    } seg_t;

    // one edge ratio in flight through the divider
    typedef struct packed {
        logic               enter;
        logic               leave;
        logic               rej;
        logic               neg;
        logic               big;
        logic [DEN_W-1:0]   den;
        logic [DEN_W:0]     rem;
        logic [QUO_BITS-1:0] quo;
    } lane_t;

    typedef struct packed {
        seg_t                      seg;
        lane_t [NUM_EDGES-1:0]     lane;
    } div_t;

    typedef struct packed {
        seg_t               seg;
        logic               visible;
        logic [PARAM_W-1:0] entry;
        logic [PARAM_W-1:0] leave;
    } cmb_t;

    typedef struct packed {
        seg_t                     seg;
        logic                     visible;
        logic [PARAM_W-1:0]       entry;
        logic [PARAM_W-1:0]       leave;
        logic signed [PROD_W-1:0] pxa;
        logic signed [PROD_W-1:0] pya;
        logic signed [PROD_W-1:0] pxb;
        logic signed [PROD_W-1:0] pyb;
    } mul_t;

    typedef struct packed {
        logic                         visible;
        logic signed [COORD_BITS-1:0] csx;
        logic signed [COORD_BITS-1:0] csy;
        logic signed [COORD_BITS-1:0] cex;
        logic signed [COORD_BITS-1:0] cey;
        logic [PARAM_W-1:0]           entry;
        logic [PARAM_W-1:0]           leave;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/liang_barsky_line_clip_core.sv @@
// liang-barsky segment clipper against a configured axis-aligned window
// depends on lblc_pkg for formats, register codes and payload structs
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  s_      | in        | s_tvalid / s_tready    | s_tdata: start_x, start_y, end_x, end_y
//  m_      | out       | m_tvalid / m_tready    | m_tdata: clipped points, entry, exit
//          |           |                        | m_tuser: visible
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one beat per cycle sustained while m_tready stays high; stages in order: setup,
//  three divider stages at six quotient bits each, min/max combine, multiply, and
//  output add with saturation.
//  rst_n clears all valid bits and the window registers; data needs no reset.
//  a stall only holds the stages that are full; empty stages keep filling.
module liang_barsky_line_clip_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
    input  wire logic [63:0]  s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // clip_start_x[15:0], clip_start_y[31:16], clip_end_x[47:32],
    // clip_end_y[63:48], entry_param[80:64], exit_param[97:81], zero pad
    output logic [103:0]      m_tdata,
    // visible[0]
    output logic [0:0]        m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lblc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lblc_pkg::COORD_BITS-1:0] cfg_data
);

    localparam int CW    = lblc_pkg::COORD_BITS;
    localparam int S_CMB = lblc_pkg::DIV_STAGES + 1;
    localparam int S_MUL = lblc_pkg::DIV_STAGES + 2;
    localparam int S_OUT = lblc_pkg::DIV_STAGES + 3;
    localparam int NST   = lblc_pkg::DIV_STAGES + 4;

    // window registers
    logic signed [CW-1:0] center_x_reg;
    logic signed [CW-1:0] center_y_reg;
    logic [CW-1:0]        length_reg;
    logic [CW-1:0]        breadth_reg;

    // pipeline registers
    logic [NST-1:0]  valid_reg;
    logic [NST:0]    adv;
    lblc_pkg::div_t  div_reg [0:lblc_pkg::DIV_STAGES];
    lblc_pkg::div_t  div_next;
    lblc_pkg::cmb_t  cmb_reg;
    lblc_pkg::cmb_t  cmb_next;
    lblc_pkg::mul_t  mul_reg;
    lblc_pkg::mul_t  mul_next;
    lblc_pkg::res_t  out_reg;
    lblc_pkg::res_t  out_next;

    // saturate a doubled edge coordinate
    function automatic logic signed [lblc_pkg::EDGE_W-1:0] sat_edge(
        input logic signed [lblc_pkg::EDGE_W-1:0] v);
        logic signed [lblc_pkg::EDGE_W-1:0] r;
        if (v < lblc_pkg::EDGE_LO)
            r = lblc_pkg::EDGE_LO;
        else if (v > lblc_pkg::EDGE_HI)
            r = lblc_pkg::EDGE_HI;
        else
            r = v;
        return r;
    endfunction

    // classify one edge and load its divider lane
    function automatic lblc_pkg::lane_t lane_init(
        input logic signed [lblc_pkg::EDGE_W-1:0] p,
        input logic signed [lblc_pkg::EDGE_W-1:0] q);
        lblc_pkg::lane_t l;
        logic signed [lblc_pkg::EDGE_W-1:0] num;
        logic signed [lblc_pkg::EDGE_W-1:0] den;
        num     = (p < 0) ? -q : q;
        den     = (p < 0) ? -p : p;
        l.enter = (p < 0);
        l.leave = (p > 0);
        l.rej   = (p == 0) && (q < 0);
        l.neg   = (num < 0);
        l.big   = (num > den);
        l.den   = den[lblc_pkg::DEN_W-1:0];
        l.rem   = num[lblc_pkg::DEN_W:0];
        l.quo   = '0;
        return l;
    endfunction

    // restoring division steps for all lanes, starting at quotient bit first
    function automatic lblc_pkg::div_t div_advance(
        input lblc_pkg::div_t d,
        input int first);
        lblc_pkg::div_t r;
        logic [lblc_pkg::DEN_W:0] trial;
        int g;
        r = d;
        for (int e = 0; e < lblc_pkg::NUM_EDGES; e++)
        begin
            for (int j = 0; j < lblc_pkg::DIV_STEPS; j++)
            begin
                g = first + j;
                if (g < lblc_pkg::QUO_BITS)
                begin
                    trial = (g == 0) ? r.lane[e].rem
                                     : {r.lane[e].rem[lblc_pkg::DEN_W-1:0], 1'b0};
                    if (trial >= {1'b0, r.lane[e].den})
                    begin
                        r.lane[e].rem = trial - {1'b0, r.lane[e].den};
                        r.lane[e].quo = {r.lane[e].quo[lblc_pkg::QUO_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        r.lane[e].rem = trial;
                        r.lane[e].quo = {r.lane[e].quo[lblc_pkg::QUO_BITS-2:0], 1'b0};
                    end
                end
            end
        end
        return r;
    endfunction

    // start + round(prod / one), saturated
    function automatic logic signed [CW-1:0] clip_pt(
        input logic signed [CW-1:0] s,
        input logic signed [lblc_pkg::PROD_W-1:0] prod);
        logic signed [lblc_pkg::PROD_W:0] rounded;
        logic signed [lblc_pkg::PROD_W:0] sum;
        logic signed [lblc_pkg::PROD_W:0] lo;
        logic signed [lblc_pkg::PROD_W:0] hi;
        logic signed [CW-1:0] r;
        lo      = (lblc_pkg::PROD_W+1)'(-(64'sd1 <<< (CW - 1)));
        hi      = (lblc_pkg::PROD_W+1)'((64'sd1 <<< (CW - 1)) - 1);
        rounded = ((lblc_pkg::PROD_W+1)'(prod)
                   + (lblc_pkg::PROD_W+1)'(64'sd1 <<< (lblc_pkg::PARAM_FRAC_BITS - 1)))
                  >>> lblc_pkg::PARAM_FRAC_BITS;
        sum     = rounded + (lblc_pkg::PROD_W+1)'(s);
        if (sum < lo)
            r = lo[CW-1:0];
        else if (sum > hi)
            r = hi[CW-1:0];
        else
            r = sum[CW-1:0];
        return r;
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            length_reg   <= '0;
            breadth_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lblc_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                lblc_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                lblc_pkg::REG_LENGTH:   length_reg   <= cfg_data;
                lblc_pkg::REG_BREADTH:  breadth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain, back from the output
    always_comb
    begin
        adv[NST] = m_tready;
        for (int i = NST - 1; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[0])
                valid_reg[0] <= s_tvalid;
            for (int i = 1; i < NST; i++)
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // setup: window edges, deltas and one divider lane per edge
    always_comb
    begin
        logic signed [lblc_pkg::EDGE_W-1:0] cx2, cy2, len_e, br_e;
        logic signed [lblc_pkg::EDGE_W-1:0] xmin2, xmax2, ymin2, ymax2;
        logic signed [lblc_pkg::EDGE_W-1:0] sx2, sy2, dx2, dy2;
        logic signed [CW-1:0] sx, sy, ex, ey;
        sx    = s_tdata[CW-1:0];
        sy    = s_tdata[2*CW-1:CW];
        ex    = s_tdata[3*CW-1:2*CW];
        ey    = s_tdata[4*CW-1:3*CW];
        cx2   = lblc_pkg::EDGE_W'(center_x_reg) <<< 1;
        cy2   = lblc_pkg::EDGE_W'(center_y_reg) <<< 1;
        len_e = lblc_pkg::EDGE_W'(length_reg);
        br_e  = lblc_pkg::EDGE_W'(breadth_reg);
        xmin2 = sat_edge(cx2 - len_e);
        xmax2 = sat_edge(cx2 + len_e);
        ymin2 = sat_edge(cy2 - br_e);
        ymax2 = sat_edge(cy2 + br_e);
        div_next.seg.sx = sx;
        div_next.seg.sy = sy;
        div_next.seg.dx = (CW+1)'(ex) - (CW+1)'(sx);
        div_next.seg.dy = (CW+1)'(ey) - (CW+1)'(sy);
        sx2 = lblc_pkg::EDGE_W'(sx) <<< 1;
        sy2 = lblc_pkg::EDGE_W'(sy) <<< 1;
        dx2 = lblc_pkg::EDGE_W'(div_next.seg.dx) <<< 1;
        dy2 = lblc_pkg::EDGE_W'(div_next.seg.dy) <<< 1;
        div_next.lane[0] = lane_init(-dx2, sx2 - xmin2);
        div_next.lane[1] = lane_init(dx2, xmax2 - sx2);
        div_next.lane[2] = lane_init(-dy2, sy2 - ymin2);
        div_next.lane[3] = lane_init(dy2, ymax2 - sy2);
    end

    // combine: rounded ratios into entry and exit, visibility
    always_comb
    begin
        logic [lblc_pkg::QUO_BITS:0] rsum;
        logic [lblc_pkg::PARAM_W-1:0] r;
        logic bad;
        cmb_next.seg   = div_reg[lblc_pkg::DIV_STAGES].seg;
        cmb_next.entry = '0;
        cmb_next.leave = lblc_pkg::PARAM_ONE;
        bad = 1'b0;
        for (int e = 0; e < lblc_pkg::NUM_EDGES; e++)
        begin
            rsum = (lblc_pkg::QUO_BITS+1)'(div_reg[lblc_pkg::DIV_STAGES].lane[e].quo)
                   + (lblc_pkg::QUO_BITS+1)'(1);
            r    = rsum[lblc_pkg::PARAM_W:1];
            if (div_reg[lblc_pkg::DIV_STAGES].lane[e].rej)
                bad = 1'b1;
            if (div_reg[lblc_pkg::DIV_STAGES].lane[e].enter)
            begin
                if (div_reg[lblc_pkg::DIV_STAGES].lane[e].big)
                    bad = 1'b1;
                else if (!div_reg[lblc_pkg::DIV_STAGES].lane[e].neg && r > cmb_next.entry)
                    cmb_next.entry = r;
            end
            if (div_reg[lblc_pkg::DIV_STAGES].lane[e].leave)
            begin
                if (div_reg[lblc_pkg::DIV_STAGES].lane[e].neg)
                    bad = 1'b1;
                else if (!div_reg[lblc_pkg::DIV_STAGES].lane[e].big && r < cmb_next.leave)
                    cmb_next.leave = r;
            end
        end
        cmb_next.visible = !bad && (cmb_next.entry <= cmb_next.leave);
    end

    // multiply deltas by both parameters
    always_comb
    begin
        logic signed [lblc_pkg::PARAM_W:0] ta, tb;
        ta = {1'b0, cmb_reg.entry};
        tb = {1'b0, cmb_reg.leave};
        mul_next.seg     = cmb_reg.seg;
        mul_next.visible = cmb_reg.visible;
        mul_next.entry   = cmb_reg.entry;
        mul_next.leave   = cmb_reg.leave;
        mul_next.pxa     = cmb_reg.seg.dx * ta;
        mul_next.pya     = cmb_reg.seg.dy * ta;
        mul_next.pxb     = cmb_reg.seg.dx * tb;
        mul_next.pyb     = cmb_reg.seg.dy * tb;
    end

    // output: clipped points, zero when rejected
    always_comb
    begin
        out_next = '0;
        if (mul_reg.visible)
        begin
            out_next.visible = 1'b1;
            out_next.csx     = clip_pt(mul_reg.seg.sx, mul_reg.pxa);
            out_next.csy     = clip_pt(mul_reg.seg.sy, mul_reg.pya);
            out_next.cex     = clip_pt(mul_reg.seg.sx, mul_reg.pxb);
            out_next.cey     = clip_pt(mul_reg.seg.sy, mul_reg.pyb);
            out_next.entry   = mul_reg.entry;
            out_next.leave   = mul_reg.leave;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
            div_reg[0] <= div_next;
        for (int k = 1; k <= lblc_pkg::DIV_STAGES; k++)
            if (adv[k])
                div_reg[k] <= div_advance(div_reg[k-1], (k - 1) * lblc_pkg::DIV_STEPS);
        if (adv[S_CMB])
            cmb_reg <= cmb_next;
        if (adv[S_MUL])
            mul_reg <= mul_next;
        if (adv[S_OUT])
            out_reg <= out_next;
    end

    assign m_tvalid = valid_reg[S_OUT];
    assign m_tuser  = out_reg.visible;
    assign m_tdata  = {6'b0, out_reg.leave, out_reg.entry,
                       out_reg.cey, out_reg.cex, out_reg.csy, out_reg.csx};

    // rejected beats carry all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_reg.visible |-> m_tdata == '0)
        else $error("rejected segment with nonzero payload");

    // a visible result never has entry past exit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.visible |-> out_reg.entry <= out_reg.leave)
        else $error("visible segment with entry after exit");

    // the exit parameter stays within one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.leave <= lblc_pkg::PARAM_ONE)
        else $error("exit parameter above one");

    // a held output stage keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(out_reg))
        else $error("output stage changed while stalled");

endmodule

`default_nettype wire

@@ sim/liang_barsky_line_clip_core_test.sv @@
// self-checking testbench for liang_barsky_line_clip_core: window config, segment stream
// depends on lblc_pkg and the core; predicts each clipped segment in a scoreboard class
`default_nettype none

module liang_barsky_line_clip_core_test;

    import lblc_pkg::*;

    localparam longint ONE_T  = 64'sd65536;
    localparam longint CMAX   = 64'sd32767;
    localparam longint CMIN   = -64'sd32768;
    localparam int     WATCH  = 20000;
    localparam int     LATENCY = DIV_STAGES + 4;

    // expected clipped segment
    typedef struct {
        bit               vis;
        bit signed [15:0] csx;
        bit signed [15:0] csy;
        bit signed [15:0] cex;
        bit signed [15:0] cey;
        bit [16:0]        t_in;
        bit [16:0]        t_out;
    } clip_t;

    // window model and queue of pending clipped segments
    class clip_scoreboard;
        longint cx, cy, len, br;
        clip_t  pending[$];
        int     errors;
        int     checked;
        int     shown;

        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        function longint rdiv(longint n, longint d);
            return fdiv(2 * n + d, 2 * d);
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void set_reg(cfg_reg_t idx, bit [15:0] v);
            case (idx)
                REG_CENTER_X: cx = longint'($signed(v));
                REG_CENTER_Y: cy = longint'($signed(v));
                REG_LENGTH:   len = longint'(v);
                REG_BREADTH:  br = longint'(v);
                default: ;
            endcase
        endfunction

        // tighten the parameter interval by one edge; false when parallel and outside
        function bit bound_edge(longint p, longint q, inout longint t_in, inout longint t_out);
            longint n, d, r;
            if (p == 0)
                return q >= 0;
            n = p < 0 ? -q : q;
            d = p < 0 ? -p : p;
            r = rdiv(n * ONE_T, d);
            if (p < 0 && r > t_in)
                t_in = r;
            if (p > 0 && r < t_out)
                t_out = r;
            return 1;
        endfunction

        function void note_segment(bit [63:0] seg);
            longint sx, sy, ex, ey, dx, dy, x0, x1, y0, y1, t_in, t_out;
            bit     ok;
            clip_t  c;
            sx = longint'($signed(seg[15:0]));
            sy = longint'($signed(seg[31:16]));
            ex = longint'($signed(seg[47:32]));
            ey = longint'($signed(seg[63:48]));
            dx = ex - sx;
            dy = ey - sy;
            x0 = sat(2 * cx - len, 2 * CMIN, 2 * CMAX);
            x1 = sat(2 * cx + len, 2 * CMIN, 2 * CMAX);
            y0 = sat(2 * cy - br, 2 * CMIN, 2 * CMAX);
            y1 = sat(2 * cy + br, 2 * CMIN, 2 * CMAX);
            t_in = 0;
            t_out = ONE_T;
            ok = 1;
            if (!bound_edge(-2 * dx, 2 * sx - x0, t_in, t_out)) ok = 0;
            if (!bound_edge(2 * dx, x1 - 2 * sx, t_in, t_out)) ok = 0;
            if (!bound_edge(-2 * dy, 2 * sy - y0, t_in, t_out)) ok = 0;
            if (!bound_edge(2 * dy, y1 - 2 * sy, t_in, t_out)) ok = 0;
            if (t_in > t_out)
                ok = 0;
            c = '{default: 0};
            if (ok)
            begin
                c.vis = 1;
                c.csx = 16'(sat(sx + rdiv(dx * t_in, ONE_T), CMIN, CMAX));
                c.csy = 16'(sat(sy + rdiv(dy * t_in, ONE_T), CMIN, CMAX));
                c.cex = 16'(sat(sx + rdiv(dx * t_out, ONE_T), CMIN, CMAX));
                c.cey = 16'(sat(sy + rdiv(dy * t_out, ONE_T), CMIN, CMAX));
                c.t_in = 17'(t_in);
                c.t_out = 17'(t_out);
            end
            pending.push_back(c);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (shown < 40)
            begin
                shown++;
                $display("mismatch on result %0d: %s got %0d expected %0d",
                         checked, what, got, want);
            end
        endtask

        task check_result(bit [103:0] d, bit vis);
            clip_t c;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 1, 0);
                return;
            end
            c = pending.pop_front();
            if (vis != c.vis) report("visible", vis, c.vis);
            if (d[15:0] != c.csx) report("clip_start_x", $signed(d[15:0]), c.csx);
            if (d[31:16] != c.csy) report("clip_start_y", $signed(d[31:16]), c.csy);
            if (d[47:32] != c.cex) report("clip_end_x", $signed(d[47:32]), c.cex);
            if (d[63:48] != c.cey) report("clip_end_y", $signed(d[63:48]), c.cey);
            if (d[80:64] != c.t_in) report("entry_param", d[80:64], c.t_in);
            if (d[97:81] != c.t_out) report("exit_param", d[97:81], c.t_out);
            checked++;
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic [63:0]  s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COORD_BITS-1:0] cfg_data;

    clip_scoreboard board;
    int  idle_cycles;
    int  sent;
    int  visible_seen;
    bit  hold_off;
    bit  stall_on;

    liang_barsky_line_clip_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result beats checked at the edge where they are taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata, m_tuser[0]);
            if (m_tuser[0])
                visible_seen++;
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else if (!stall_on)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles with no beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH)
        begin
            $display("watchdog expired");
            $display("liang_barsky_line_clip_core regression: fail");
            $finish;
        end
    end

    // one register beat; valid stays high across consecutive writes
    task automatic write_reg(cfg_reg_t idx, bit [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, v);
    endtask

    task automatic set_window(bit [15:0] x, bit [15:0] y, bit [15:0] l, bit [15:0] b);
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_LENGTH, l);
        write_reg(REG_BREADTH, b);
        cfg_valid <= 1'b0;
    endtask

    // one segment beat; valid stays high across back-to-back beats
    task automatic send_segment(bit [15:0] sx, bit [15:0] sy, bit [15:0] ex, bit [15:0] ey,
                                bit keep);
        s_tvalid <= 1'b1;
        s_tdata <= {ey, ex, sy, sx};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_segment({ey, ex, sy, sx});
        sent++;
        if (!keep)
            s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);
    endtask

    function automatic bit [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1600)) - 800);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    // random bursts of segments, mostly near the window
    task automatic random_phase(int count);
        int n, burst, mode;
        bit [15:0] sx, sy;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < count; k++)
            begin
                mode = $urandom_range(0, 9);
                mode = mode < 2 ? 0 : (mode < 3 ? 2 : (mode < 6 ? 1 : 3));
                sx = pick_coord(mode);
                sy = pick_coord(mode);
                case ($urandom_range(0, 7))
                    0: send_segment(sx, sy, sx, pick_coord(mode), 1);
                    1: send_segment(sx, sy, pick_coord(mode), sy, 1);
                    2: send_segment(sx, sy, sx, sy, 1);
                    default: send_segment(sx, sy, pick_coord(mode), pick_coord(mode), 1);
                endcase
                n++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        board.cx = 0;
        board.cy = 0;
        board.len = 0;
        board.br = 0;
        idle_cycles = 0;
        sent = 0;
        visible_seen = 0;
        hold_off = 1'b0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: a single point at the origin
        send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
        send_segment(16'hfff0, 16'h0000, 16'h0010, 16'h0000, 0);
        drain();

        // directed: window 1024x512 units centered at (128,-64)
        set_window(16'h0080, 16'hffc0, 16'h0400, 16'h0200);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1);
        send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1);
        send_segment(16'h0000, 16'h0000, 16'h0040, 16'h0020, 1);
        send_segment(16'h0080, 16'h0000, 16'h0080, 16'h0000, 1);
        send_segment(16'h7000, 16'h7000, 16'h7000, 16'h7000, 1);
        send_segment(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 1);
        send_segment(16'h8000, 16'h4000, 16'h7fff, 16'h4000, 1);
        send_segment(16'h0000, 16'h8000, 16'h0000, 16'h7fff, 1);
        send_segment(16'h5000, 16'h8000, 16'h5000, 16'h7fff, 1);
        send_segment(16'h0280, 16'h0000, 16'hfe80, 16'h0000, 1);
        send_segment(16'hfe80, 16'hff40, 16'h0280, 16'hff40, 1);
        send_segment(16'h0000, 16'h0000, 16'h0001, 16'h0001, 0);
        drain();

        // extremes: widest window at the origin, then at the far corner
        set_window(16'h0000, 16'h0000, 16'hffff, 16'hffff);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1);
        send_segment(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 0);
        drain();
        set_window(16'h7fff, 16'h8000, 16'hffff, 16'h0000);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1);
        send_segment(16'h0000, 16'h8000, 16'h0000, 16'h7fff, 0);
        drain();

        // random: typical window with receiver stalls
        set_window(16'h0040, 16'hffe0, 16'h0c00, 16'h0800);
        stall_on = 1'b1;
        random_phase(250);
        drain();

        // long receiver hold-off so the pipe fills and stalls its input
        fork
            begin
                hold_off = 1'b1;
                repeat (60)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(40);
        join
        drain();

        // random windows of all sizes
        for (int w = 0; w < 7; w++)
        begin
            set_window(pick_coord(w % 4 == 0 ? 0 : 3), pick_coord(w % 4 == 0 ? 0 : 3),
                       w == 6 ? 16'h0000 : 16'($urandom_range(0, 16'hffff) >> (w % 4)),
                       w == 5 ? 16'hffff : 16'($urandom_range(0, 16'hffff) >> (w % 4)));
            random_phase(80);
            drain();
        end

        $display("sent %0d segments over 11 window settings; %0d results, %0d visible",
                 sent, board.checked, visible_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("liang_barsky_line_clip_core regression: pass");
        else
            $display("liang_barsky_line_clip_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
